### rtl/ibt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_pkg
// Shared types and constants of the IoU greedy box tracker.
// ----------------------------------------------------------------------------
package ibt_pkg;

    localparam int IDENT_W  = 16;
    localparam int MISSED_W = 9;
    localparam int IOU_W    = 17;
    localparam int LIMIT_W  = 8;
    localparam int LIVE_W   = 5;
    localparam int KIND_W   = 2;
    localparam int OP_W     = 2;

    localparam logic [MISSED_W-1:0] MISSED_MAX   = 9'd511;
    localparam logic [IDENT_W-1:0]  IDENT_FIRST  = 16'd1;
    localparam logic [IDENT_W-1:0]  IDENT_LAST   = 16'hFFFF;
    localparam logic [IOU_W-1:0]    THRESH_RESET = 17'd32768;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd3;

    localparam logic [OP_W-1:0] OP_FRAME_START = 2'd0;
    localparam logic [OP_W-1:0] OP_DETECT      = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAME_END   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR       = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd3;

    localparam logic REG_THRESHOLD  = 1'b0;
    localparam logic REG_MISS_LIMIT = 1'b1;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                shift;
        logic                age;
        logic                clr_all;
        logic                clr_cand;
        logic                wr;
        logic                wr_new;
        logic [IDENT_W-1:0]  wr_ident;
    } ibt_ctrl_t;

endpackage

### rtl/iou_greedy_box_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_greedy_box_tracker
// Greedy IoU multi-object tracker built on a ring of track-slot cells.
// ----------------------------------------------------------------------------
// The track table lives in a ring of MAX_TRACKS cells that rotates one slot
// per step past a head cell; a full pass brings every slot back home. Items
// are taken one at a time. A detection rotates the ring once; each live
// candidate slot holds the ring for one run of the shared IoU unit
// (geometry, area products, and a 17-step restoring divide, cut short when
// either box is degenerate), and the result word waits on any output stall.
// Frame end rotates the ring once and waits on any output stall, with one
// expired word per removed track.
// ----------------------------------------------------------------------------
module iou_greedy_box_tracker
    import ibt_pkg::*;
#(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], box_left[17:2], box_top[33:18], box_right[49:34],
    // box_bottom[65:50], zero fill[71:66]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // track_number[15:0], overlap[32:16], status[33], live_count[38:34],
    // zero fill[39]
    output logic [39:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int CB    = COORD_BITS;
    localparam int BOX_W = 4 * CB;
    localparam int IW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW    = $clog2(MAX_TRACKS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ACK    = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_FEND   = 3'd5;
    localparam logic [2:0] S_FDONE  = 3'd6;

    // configuration
    logic [IOU_W-1:0]   thr_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // sequencer
    logic [2:0]         state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [BOX_W-1:0]   det_reg, det_next;
    logic               best_found_reg, best_found_next;
    logic [IOU_W-1:0]   best_iou_reg, best_iou_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic [IDENT_W-1:0] best_ident_reg, best_ident_next;
    logic               free_found_reg, free_found_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    logic [IDENT_W-1:0] nid_reg, nid_next;
    logic [CW-1:0]      live_reg, live_next;

    // output word
    logic               ov_valid_reg;
    logic [KIND_W-1:0]  o_kind_reg;
    logic [IDENT_W-1:0] o_id_reg;
    logic [IOU_W-1:0]   o_ov_reg;
    logic               o_st_reg;
    logic [LIVE_W-1:0]  o_cnt_reg;
    logic               o_last_reg;

    logic               ld;
    logic [KIND_W-1:0]  ld_kind;
    logic [IDENT_W-1:0] ld_id;
    logic [IOU_W-1:0]   ld_ov;
    logic               ld_st;
    logic [CW-1:0]      ld_cnt;
    logic               ld_last;

    logic               out_free;
    logic               accept;
    logic               last_step;
    ibt_ctrl_t          ctrl;
    logic               drop;
    logic [IW-1:0]      wr_slot;
    logic               iou_start;
    logic               iou_done;
    logic [IOU_W-1:0]   iou_val;
    logic [BOX_W-1:0]   in_box;

    logic                c_live   [MAX_TRACKS];
    logic                c_cand   [MAX_TRACKS];
    logic [IDENT_W-1:0]  c_ident  [MAX_TRACKS];
    logic [BOX_W-1:0]    c_box    [MAX_TRACKS];
    logic [MISSED_W-1:0] c_missed [MAX_TRACKS];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !ov_valid_reg || m_tready;
    assign last_step = (idx_reg == IW'(MAX_TRACKS - 1));
    assign in_box    = {s_tdata[50 +: CB], s_tdata[34 +: CB], s_tdata[18 +: CB],
                        s_tdata[2 +: CB]};

    // ring of slot cells; the head copy loses its live bit when it expires
    genvar gi;
    generate
        for (gi = 0; gi < MAX_TRACKS; gi++)
        begin : g_cell
            logic                n_live;
            logic                n_cand;
            logic [IDENT_W-1:0]  n_ident;
            logic [BOX_W-1:0]    n_box;
            logic [MISSED_W-1:0] n_missed;

            if (gi == MAX_TRACKS - 1)
            begin : g_wrap
                assign n_live   = c_live[0] && !drop;
                assign n_cand   = c_cand[0];
                assign n_ident  = c_ident[0];
                assign n_box    = c_box[0];
                assign n_missed = c_missed[0];
            end
            else
            begin : g_link
                assign n_live   = c_live[gi+1];
                assign n_cand   = c_cand[gi+1];
                assign n_ident  = c_ident[gi+1];
                assign n_box    = c_box[gi+1];
                assign n_missed = c_missed[gi+1];
            end

            ibt_cell #(
                .BOX_W (BOX_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .wr_sel    (wr_slot == IW'(gi)),
                .wr_box    (det_reg),
                .nb_live   (n_live),
                .nb_cand   (n_cand),
                .nb_ident  (n_ident),
                .nb_box    (n_box),
                .nb_missed (n_missed),
                .live      (c_live[gi]),
                .cand      (c_cand[gi]),
                .ident     (c_ident[gi]),
                .box       (c_box[gi]),
                .missed    (c_missed[gi])
            );
        end
    endgenerate

    ibt_iou #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .clk   (clk),
        .rst_n (rst_n),
        .start (iou_start),
        .box_a (c_box[0]),
        .box_b (det_reg),
        .done  (iou_done),
        .value (iou_val)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        det_next        = det_reg;
        best_found_next = best_found_reg;
        best_iou_next   = best_iou_reg;
        best_idx_next   = best_idx_reg;
        best_ident_next = best_ident_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        nid_next        = nid_reg;
        live_next       = live_reg;
        ctrl            = '0;
        drop            = 1'b0;
        wr_slot         = '0;
        iou_start       = 1'b0;
        ld              = 1'b0;
        ld_kind         = KIND_ACK;
        ld_id           = '0;
        ld_ov           = '0;
        ld_st           = 1'b0;
        ld_cnt          = live_reg;
        ld_last         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    case (s_tdata[1:0])
                        OP_FRAME_START:
                        begin
                            ctrl.age   = 1'b1;
                            state_next = S_ACK;
                        end
                        OP_DETECT:
                        begin
                            det_next        = in_box;
                            best_found_next = 1'b0;
                            best_iou_next   = '0;
                            free_found_next = 1'b0;
                            state_next      = S_CMP;
                        end
                        OP_FRAME_END:
                        begin
                            state_next = S_FEND;
                        end
                        OP_CLEAR:
                        begin
                            ctrl.clr_all = 1'b1;
                            live_next    = '0;
                            nid_next     = IDENT_FIRST;
                            state_next   = S_ACK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_kind    = KIND_ACK;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (c_live[0] && c_cand[0])
                begin
                    iou_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    if (!c_live[0] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    ctrl.shift = 1'b1;
                    if (last_step)
                        state_next = S_DECIDE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (iou_done)
                begin
                    // strict compare keeps the lowest slot on a tie
                    if (iou_val > best_iou_reg)
                    begin
                        best_found_next = 1'b1;
                        best_iou_next   = iou_val;
                        best_idx_next   = idx_reg;
                        best_ident_next = c_ident[0];
                    end
                    ctrl.shift = 1'b1;
                    if (last_step)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_CMP;
                    end
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    ld         = 1'b1;
                    ld_kind    = KIND_ASSIGN;
                    ld_ov      = best_iou_reg;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                    if (best_found_reg && (best_iou_reg >= thr_reg))
                    begin
                        ctrl.wr = 1'b1;
                        wr_slot = best_idx_reg;
                        ld_id   = best_ident_reg;
                    end
                    else if (free_found_reg)
                    begin
                        ctrl.wr       = 1'b1;
                        ctrl.wr_new   = 1'b1;
                        ctrl.wr_ident = nid_reg;
                        wr_slot       = free_idx_reg;
                        ld_id         = nid_reg;
                        live_next     = live_reg + 1'b1;
                        ld_cnt        = live_next;
                        nid_next      = (nid_reg == IDENT_LAST) ? IDENT_FIRST
                                                                : nid_reg + 1'b1;
                    end
                    else
                    begin
                        ld_st = 1'b1;
                    end
                end
            end
            S_FEND:
            begin
                if (c_live[0] && (c_missed[0] > {1'b0, limit_reg}))
                begin
                    if (out_free)
                    begin
                        drop       = 1'b1;
                        ctrl.shift = 1'b1;
                        live_next  = live_reg - 1'b1;
                        ld         = 1'b1;
                        ld_kind    = KIND_EXPIRED;
                        ld_id      = c_ident[0];
                        ld_cnt     = live_next;
                        if (last_step)
                            state_next = S_FDONE;
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    if (last_step)
                        state_next = S_FDONE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            S_FDONE:
            begin
                if (out_free)
                begin
                    ctrl.clr_cand = 1'b1;
                    ld            = 1'b1;
                    ld_kind       = KIND_DONE;
                    ld_last       = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THRESH_RESET;
            limit_reg      <= LIMIT_RESET;
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            nid_reg        <= IDENT_FIRST;
            live_reg       <= '0;
            ov_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD:  thr_reg   <= cfg_data;
                    REG_MISS_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:        thr_reg   <= thr_reg;
                endcase
            end
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
            nid_reg        <= nid_next;
            live_reg       <= live_next;
            if (ld)
                ov_valid_reg <= 1'b1;
            else if (m_tready)
                ov_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg        <= det_next;
        best_iou_reg   <= best_iou_next;
        best_idx_reg   <= best_idx_next;
        best_ident_reg <= best_ident_next;
        free_idx_reg   <= free_idx_next;
        if (ld)
        begin
            o_kind_reg <= ld_kind;
            o_id_reg   <= ld_id;
            o_ov_reg   <= ld_ov;
            o_st_reg   <= ld_st;
            o_cnt_reg  <= LIVE_W'(ld_cnt);
            o_last_reg <= ld_last;
        end
    end

    assign m_tvalid = ov_valid_reg;
    assign m_tdata  = {1'b0, o_cnt_reg, o_st_reg, o_ov_reg, o_id_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(MAX_TRACKS))
        else $error("live track count above table size");

    a_iou_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        iou_done |-> (state_reg == S_DIV))
        else $error("IoU result arrived outside of compare wait");

    a_ident_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        nid_reg != '0)
        else $error("next track ID reached zero");

    a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_valid_reg && (o_kind_reg == KIND_EXPIRED)) |-> !o_last_reg)
        else $error("expired word marked as final");

endmodule

### rtl/ibt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_cell
// One track slot of the ring; takes its neighbor's slot on a shift.
// ----------------------------------------------------------------------------
module ibt_cell
    import ibt_pkg::*;
#(
    parameter int BOX_W = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ibt_ctrl_t           ctrl,
    input  logic                wr_sel,
    input  logic [BOX_W-1:0]    wr_box,
    input  logic                nb_live,
    input  logic                nb_cand,
    input  logic [IDENT_W-1:0]  nb_ident,
    input  logic [BOX_W-1:0]    nb_box,
    input  logic [MISSED_W-1:0] nb_missed,
    output logic                live,
    output logic                cand,
    output logic [IDENT_W-1:0]  ident,
    output logic [BOX_W-1:0]    box,
    output logic [MISSED_W-1:0] missed
);

    logic                live_reg, live_next;
    logic                cand_reg, cand_next;
    logic [IDENT_W-1:0]  ident_reg, ident_next;
    logic [BOX_W-1:0]    box_reg, box_next;
    logic [MISSED_W-1:0] missed_reg, missed_next;

    always_comb
    begin
        live_next   = live_reg;
        cand_next   = cand_reg;
        ident_next  = ident_reg;
        box_next    = box_reg;
        missed_next = missed_reg;
        if (ctrl.clr_all)
        begin
            live_next = 1'b0;
            cand_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            live_next   = nb_live;
            cand_next   = nb_cand;
            ident_next  = nb_ident;
            box_next    = nb_box;
            missed_next = nb_missed;
        end
        else if (ctrl.age)
        begin
            if (live_reg)
            begin
                cand_next = 1'b1;
                if (missed_reg < MISSED_MAX)
                    missed_next = missed_reg + 1'b1;
            end
        end
        else if (ctrl.wr && wr_sel)
        begin
            live_next   = 1'b1;
            cand_next   = 1'b0;
            box_next    = wr_box;
            missed_next = '0;
            if (ctrl.wr_new)
                ident_next = ctrl.wr_ident;
        end
        else if (ctrl.clr_cand)
        begin
            cand_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
            cand_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ident_reg  <= ident_next;
        box_reg    <= box_next;
        missed_reg <= missed_next;
    end

    assign live   = live_reg;
    assign cand   = cand_reg;
    assign ident  = ident_reg;
    assign box    = box_reg;
    assign missed = missed_reg;

endmodule

### rtl/ibt_iou.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_iou
// Multi-cycle IoU unit: geometry, area products, then a restoring divider.
// ----------------------------------------------------------------------------
module ibt_iou
    import ibt_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [4*COORD_BITS-1:0] box_a,
    input  logic [4*COORD_BITS-1:0] box_b,
    output logic                    done,
    output logic [IOU_W-1:0]        value
);

    localparam int CB = COORD_BITS;
    localparam int PW = 2 * CB;
    localparam int UW = PW + 1;
    localparam int RW = PW + 2;
    localparam int QB = IOU_W;
    localparam int CNT_W = $clog2(QB);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_UNI  = 2'd2;
    localparam logic [1:0] P_DIV  = 2'd3;

    logic [1:0]       phase_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             deg_reg;
    logic [CB-1:0]    iw_reg, ih_reg, wa_reg, ha_reg, wb_reg, hb_reg;
    logic [PW-1:0]    inter_reg, aa_reg, ab_reg;
    logic [UW-1:0]    uni_reg;
    logic [RW-1:0]    rem_reg;
    logic [QB-1:0]    nb_reg;
    logic [QB-1:0]    q_reg;

    logic [CB-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic [CB-1:0] minr, maxl, minb, maxt;
    logic          deg;
    logic [RW-1:0] r2;
    logic          ge;

    always_comb
    begin
        al = box_a[CB-1:0];
        at = box_a[2*CB-1:CB];
        ar = box_a[3*CB-1:2*CB];
        ab = box_a[4*CB-1:3*CB];
        bl = box_b[CB-1:0];
        bt = box_b[2*CB-1:CB];
        br = box_b[3*CB-1:2*CB];
        bb = box_b[4*CB-1:3*CB];
        minr = (ar < br) ? ar : br;
        maxl = (al > bl) ? al : bl;
        minb = (ab < bb) ? ab : bb;
        maxt = (at > bt) ? at : bt;
        deg  = (ar <= al) || (ab <= at) || (br <= bl) || (bb <= bt);
        r2   = {rem_reg[RW-2:0], nb_reg[QB-1]};
        ge   = (r2 >= RW'(uni_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                        phase_reg <= P_MUL;
                end
                P_MUL:
                begin
                    if (deg_reg)
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= P_IDLE;
                    end
                    else
                    begin
                        phase_reg <= P_UNI;
                    end
                end
                P_UNI:
                begin
                    cnt_reg   <= '0;
                    phase_reg <= P_DIV;
                end
                P_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(QB - 1))
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= P_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_IDLE:
            begin
                deg_reg <= deg;
                iw_reg  <= (minr > maxl) ? (minr - maxl) : '0;
                ih_reg  <= (minb > maxt) ? (minb - maxt) : '0;
                wa_reg  <= ar - al;
                ha_reg  <= ab - at;
                wb_reg  <= br - bl;
                hb_reg  <= bb - bt;
            end
            P_MUL:
            begin
                inter_reg <= iw_reg * ih_reg;
                aa_reg    <= wa_reg * ha_reg;
                ab_reg    <= wb_reg * hb_reg;
                q_reg     <= '0;
            end
            P_UNI:
            begin
                uni_reg <= UW'(aa_reg) + UW'(ab_reg) - UW'(inter_reg);
                // quotient fits 17 bits: start from inter / 2 and feed inter[0]
                rem_reg <= RW'(inter_reg >> 1);
                nb_reg  <= {inter_reg[0], {(QB-1){1'b0}}};
            end
            P_DIV:
            begin
                rem_reg <= ge ? (r2 - RW'(uni_reg)) : r2;
                nb_reg  <= {nb_reg[QB-2:0], 1'b0};
                q_reg   <= {q_reg[QB-2:0], ge};
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign done  = done_reg;
    assign value = q_reg;

endmodule
